// ===== rtl/ged_pkg.sv =====
`default_nettype none
package ged_pkg;

	localparam logic [15:0] DEBOUNCE_RESET = 16'd40;
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic        found;
		logic [6:0]  pin;
		logic        rising;
		logic [31:0] now_ticks;
		logic [31:0] now_seconds;
	} item_t;

	typedef struct packed {
		logic [31:0] fall_ticks;
		logic [31:0] rise_ticks;
		logic [31:0] start_sec;
		logic [31:0] end_sec;
	} rec_t;

	typedef struct packed {
		logic found;
		logic notify;
		logic rising;
	} result_flags_t;

	typedef enum logic {
		BK_READ,
		BK_EXEC
	} back_state_t;

endpackage
`default_nettype wire

// ===== rtl/ged_ram.sv =====
`default_nettype none
module ged_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 96
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/ged_front.sv =====
`default_nettype none
module ged_front #(
	parameter int PIN_COUNT = 96,
	parameter int BANK_WIDTH = 32
) (
	input  wire logic [6:0]   first_pin,
	input  wire logic [6:0]   end_pin,
	input  wire logic [31:0]  pending_bits,
	input  wire logic [31:0]  edge_bits,
	input  wire logic [31:0]  now_ticks,
	input  wire logic [31:0]  now_seconds,
	output ged_pkg::item_t    item
);
	import ged_pkg::*;

	logic [7:0]  first8;
	logic [7:0]  limit;
	logic [7:0]  bank_lim;
	logic [31:0] sel;
	logic [4:0]  idx;
	logic        hit;
	logic [7:0]  pin8;

	always_comb begin
		first8   = {1'b0, first_pin};
		bank_lim = first8 + 8'(BANK_WIDTH);
		limit    = {1'b0, end_pin};
		if (limit > 8'(PIN_COUNT)) begin
			limit = 8'(PIN_COUNT);
		end
		if (limit > bank_lim) begin
			limit = bank_lim;
		end
		for (int k = 0; k < 32; k++) begin
			sel[k] = pending_bits[k] && (first8 + 8'(k) < limit);
		end
		// lowest pending pin in range
		hit = 1'b0;
		idx = '0;
		for (int k = 31; k >= 0; k--) begin
			if (sel[k]) begin
				hit = 1'b1;
				idx = 5'(k);
			end
		end
		pin8 = first8 + {3'b000, idx};
		item.found       = hit;
		item.pin         = pin8[6:0];
		item.rising      = edge_bits[idx];
		item.now_ticks   = now_ticks;
		item.now_seconds = now_seconds;
	end
endmodule
`default_nettype wire

// ===== rtl/ged_queue.sv =====
`default_nettype none
module ged_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire ged_pkg::item_t push_item,
	output logic              full,
	input  wire logic         pop,
	output ged_pkg::item_t    head,
	output logic              empty
);
	import ged_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");
	no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into full queue");
	no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("pop from empty queue");
endmodule
`default_nettype wire

// ===== rtl/ged_back.sv =====
`default_nettype none
module ged_back #(
	parameter int PIN_COUNT = 96
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [15:0]    debounce_ticks,
	input  wire ged_pkg::item_t head,
	input  wire logic           empty,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output ged_pkg::result_flags_t flags,
	output logic [6:0]          pin,
	output logic [31:0]         event_ticks,
	output logic [31:0]         falling_ticks,
	output logic [31:0]         start_seconds,
	output logic [31:0]         end_seconds
);
	import ged_pkg::*;

	localparam int AW = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;

	back_state_t          st_q;
	back_state_t          st_d;
	item_t                cur_q;
	logic [PIN_COUNT-1:0] valid_q;
	logic                 out_valid_q;
	result_flags_t        flags_q;
	logic [6:0]           pin_q;
	logic [31:0]          event_q;
	rec_t                 rec_out_q;

	rec_t                 rd_rec;
	rec_t                 old_rec;
	rec_t                 new_rec;
	logic [31:0]          diff;
	logic                 in_win;
	logic                 report;
	logic                 load;
	logic                 we;
	logic [AW-1:0]        cur_addr;

	assign cur_addr = cur_q.pin[AW-1:0];

	ged_ram #(
		.WIDTH($bits(rec_t)),
		.DEPTH(PIN_COUNT)
	) u_rec_ram (
		.clk   (clk),
		.we    (we),
		.waddr (cur_addr),
		.wdata (new_rec),
		.re    (pop),
		.raddr (head.pin[AW-1:0]),
		.rdata (rd_rec)
	);

	always_comb begin
		old_rec = valid_q[cur_addr] ? rd_rec : '0;
		diff    = old_rec.rise_ticks + {16'h0000, debounce_ticks} - cur_q.now_ticks;
		in_win  = !diff[31];
		if (cur_q.rising) begin
			report = !((old_rec.rise_ticks != '0) && in_win);
		end else begin
			report = !in_win;
		end
		new_rec = old_rec;
		if (report) begin
			if (cur_q.rising) begin
				new_rec.rise_ticks = cur_q.now_ticks;
				new_rec.end_sec    = cur_q.now_seconds;
			end else begin
				new_rec.fall_ticks = cur_q.now_ticks;
				new_rec.start_sec  = cur_q.now_seconds;
				new_rec.end_sec    = cur_q.now_seconds;
			end
		end
	end

	always_comb begin
		st_d = st_q;
		pop  = 1'b0;
		load = 1'b0;
		case (st_q)
			BK_READ: begin
				if (!empty) begin
					pop  = 1'b1;
					st_d = BK_EXEC;
				end
			end
			BK_EXEC: begin
				if (!out_valid_q || out_ready) begin
					load = 1'b1;
					st_d = BK_READ;
				end
			end
			default: begin
				st_d = BK_READ;
			end
		endcase
		we = load && cur_q.found && report;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= BK_READ;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (we) begin
				valid_q[cur_addr] <= 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (load) begin
			if (cur_q.found) begin
				flags_q   <= '{found: 1'b1, notify: report, rising: cur_q.rising};
				pin_q     <= cur_q.pin;
				event_q   <= report ? cur_q.now_ticks : '0;
				rec_out_q <= new_rec;
			end else begin
				flags_q   <= '0;
				pin_q     <= '0;
				event_q   <= '0;
				rec_out_q <= '0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign flags         = flags_q;
	assign pin           = pin_q;
	assign event_ticks   = event_q;
	assign falling_ticks = rec_out_q.fall_ticks;
	assign start_seconds = rec_out_q.start_sec;
	assign end_seconds   = rec_out_q.end_sec;

	write_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (st_q == BK_EXEC)) else $error("record write outside exec");
	read_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (st_q == BK_EXEC)) else $error("read not followed by exec");
	result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q == BK_EXEC)) else $error("result without exec");
	no_write_unfound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BK_EXEC && !cur_q.found) |-> !we) else $error("write for empty word");
endmodule
`default_nettype wire

// ===== rtl/gpio_edge_event_debouncer.sv =====
// a word accepted goes into the queue, then to the back end, which reads the pin record
// and registers the result; it reads then writes the per-pin record ram and takes no new
// word until the last is done; a 2-entry queue lets input words be taken while it works
// reset: all per-pin records read as zero (per-pin valid flags cleared), no
// clearing pass; debounce_ticks returns to 40
`default_nettype none
module gpio_edge_event_debouncer #(
	parameter int PIN_COUNT = 96,
	parameter int BANK_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [6:0]  first_pin,
	input  wire logic [6:0]  end_pin,
	input  wire logic [31:0] pending_bits,
	input  wire logic [31:0] edge_bits,
	input  wire logic [31:0] now_ticks,
	input  wire logic [31:0] now_seconds,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             found,
	output logic [6:0]       pin,
	output logic             notify,
	output logic             edge_kind,
	output logic [31:0]      event_ticks,
	output logic [31:0]      falling_ticks,
	output logic [31:0]      start_seconds,
	output logic [31:0]      end_seconds
);
	import ged_pkg::*;

	logic [15:0]   debounce_q;
	item_t         front_item;
	item_t         head;
	logic          full;
	logic          empty;
	logic          pop;
	result_flags_t flags;

	assign cfg_ready = 1'b1;
	assign in_ready  = !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			debounce_q <= cfg_data;
		end
	end

	ged_front #(
		.PIN_COUNT (PIN_COUNT),
		.BANK_WIDTH(BANK_WIDTH)
	) u_front (
		.first_pin   (first_pin),
		.end_pin     (end_pin),
		.pending_bits(pending_bits),
		.edge_bits   (edge_bits),
		.now_ticks   (now_ticks),
		.now_seconds (now_seconds),
		.item        (front_item)
	);

	ged_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_valid && in_ready),
		.push_item(front_item),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	ged_back #(
		.PIN_COUNT(PIN_COUNT)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.debounce_ticks(debounce_q),
		.head          (head),
		.empty         (empty),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.flags         (flags),
		.pin           (pin),
		.event_ticks   (event_ticks),
		.falling_ticks (falling_ticks),
		.start_seconds (start_seconds),
		.end_seconds   (end_seconds)
	);

	assign found     = flags.found;
	assign notify    = flags.notify;
	assign edge_kind = flags.rising;
endmodule
`default_nettype wire

// ===== test/gpio_edge_event_debouncer_checker.sv =====
`timescale 1ns / 1ps
module gpio_edge_event_debouncer_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [6:0]  first_pin,
	input  wire logic [6:0]  end_pin,
	input  wire logic [31:0] pending_bits,
	input  wire logic [31:0] edge_bits,
	input  wire logic [31:0] now_ticks,
	input  wire logic [31:0] now_seconds,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic        found,
	input  wire logic [6:0]  pin,
	input  wire logic        notify,
	input  wire logic        edge_kind,
	input  wire logic [31:0] event_ticks,
	input  wire logic [31:0] falling_ticks,
	input  wire logic [31:0] start_seconds,
	input  wire logic [31:0] end_seconds,
	output int               fail_count,
	output int               outstanding,
	output int               words_in,
	output int               notified,
	output int               filtered,
	output int               empty_scans
);
	localparam int PINS = 96;
	localparam int BANK = 32;

	typedef struct packed {
		logic        found;
		logic [6:0]  pin;
		logic        notify;
		logic        edge_kind;
		logic [31:0] event_ticks;
		logic [31:0] falling_ticks;
		logic [31:0] start_seconds;
		logic [31:0] end_seconds;
	} pin_report_t;

	logic [15:0] window_ticks;
	logic [31:0] fall_at [PINS];
	logic [31:0] rise_at [PINS];
	logic [31:0] press_start [PINS];
	logic [31:0] press_end [PINS];
	pin_report_t pending_reports [$];

	function automatic logic within_window(input logic [31:0] now, input logic [31:0] rise);
		logic [31:0] gap;
		gap = rise + {16'd0, window_ticks} - now;
		return !gap[31];
	endfunction

	function automatic pin_report_t debounce_edge(input logic [6:0] first,
			input logic [6:0] last, input logic [31:0] pend, input logic [31:0] edges,
			input logic [31:0] now, input logic [31:0] secs);
		pin_report_t r;
		int stop;
		int k;
		logic rising;
		logic report;
		r = '0;
		stop = int'(last);
		if (stop > PINS)
			stop = PINS;
		if (stop > int'(first) + BANK)
			stop = int'(first) + BANK;
		for (int p = int'(first); p < stop && !r.found; p++) begin
			k = p - int'(first);
			if (pend[k]) begin
				rising = edges[k];
				if (rising) begin
					report = !(rise_at[p] != 0 && within_window(now, rise_at[p]));
					if (report) begin
						rise_at[p] = now;
						press_end[p] = secs;
					end
				end else begin
					report = !within_window(now, rise_at[p]);
					if (report) begin
						fall_at[p] = now;
						press_start[p] = secs;
						press_end[p] = secs;
					end
				end
				r.found = 1'b1;
				r.pin = 7'(p);
				r.notify = report;
				r.edge_kind = rising;
				r.event_ticks = report ? now : 32'd0;
				r.falling_ticks = fall_at[p];
				r.start_seconds = press_start[p];
				r.end_seconds = press_end[p];
			end
		end
		return r;
	endfunction

	task automatic flag_error(input string what, input pin_report_t want, input pin_report_t got);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t: %s", $realtime, what);
			$display("  want found=%0d pin=%0d notify=%0d edge=%0d ticks=%h fall=%h start=%h end=%h",
				want.found, want.pin, want.notify, want.edge_kind, want.event_ticks,
				want.falling_ticks, want.start_seconds, want.end_seconds);
			$display("  got  found=%0d pin=%0d notify=%0d edge=%0d ticks=%h fall=%h start=%h end=%h",
				got.found, got.pin, got.notify, got.edge_kind, got.event_ticks,
				got.falling_ticks, got.start_seconds, got.end_seconds);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pin_report_t got;
		pin_report_t want;
		if (!arst_n) begin
			window_ticks = ged_pkg::DEBOUNCE_RESET;
			for (int p = 0; p < PINS; p++) begin
				fall_at[p] = '0;
				rise_at[p] = '0;
				press_start[p] = '0;
				press_end[p] = '0;
			end
			pending_reports.delete();
			fail_count = 0;
			outstanding = 0;
			words_in = 0;
			notified = 0;
			filtered = 0;
			empty_scans = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				window_ticks = cfg_data;
			if (out_valid && out_ready) begin
				got = {found, pin, notify, edge_kind, event_ticks, falling_ticks,
					start_seconds, end_seconds};
				if (pending_reports.size() == 0) begin
					flag_error("result word with nothing expected", '0, got);
				end else begin
					want = pending_reports.pop_front();
					if (got !== want)
						flag_error("result word mismatch", want, got);
				end
			end
			if (in_valid && in_ready) begin
				want = debounce_edge(first_pin, end_pin, pending_bits, edge_bits,
					now_ticks, now_seconds);
				pending_reports.push_back(want);
				words_in++;
				if (!want.found)
					empty_scans++;
				else if (want.notify)
					notified++;
				else
					filtered++;
			end
			outstanding = pending_reports.size();
		end
	end

endmodule

// ===== test/gpio_edge_event_debouncer_tb.sv =====
`timescale 1ns / 1ps
module gpio_edge_event_debouncer_tb;
	localparam int PHASES = 7;
	localparam int WORDS_PER_PHASE = 200;
	localparam int LONG_HOLD = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [6:0]  first_pin = '0;
	logic [6:0]  end_pin = '0;
	logic [31:0] pending_bits = '0;
	logic [31:0] edge_bits = '0;
	logic [31:0] now_ticks = '0;
	logic [31:0] now_seconds = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        found;
	logic [6:0]  pin;
	logic        notify;
	logic        edge_kind;
	logic [31:0] event_ticks;
	logic [31:0] falling_ticks;
	logic [31:0] start_seconds;
	logic [31:0] end_seconds;

	int fail_count;
	int outstanding;
	int words_in;
	int notified;
	int filtered;
	int empty_scans;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int window_now = 40;
	logic [31:0] tick_base = '0;
	logic [31:0] sec_base = '0;

	int phase_window [PHASES] = '{40, 0, 65535, 1, -1, 40, -1};
	int phase_send_idle [PHASES] = '{0, 71, 0, 25, 0, 71, 0};
	int phase_recv_stall [PHASES] = '{0, 0, 71, 25, 0, 0, 71};

	always #1 clk = ~clk;

	gpio_edge_event_debouncer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.first_pin(first_pin),
		.end_pin(end_pin),
		.pending_bits(pending_bits),
		.edge_bits(edge_bits),
		.now_ticks(now_ticks),
		.now_seconds(now_seconds),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.pin(pin),
		.notify(notify),
		.edge_kind(edge_kind),
		.event_ticks(event_ticks),
		.falling_ticks(falling_ticks),
		.start_seconds(start_seconds),
		.end_seconds(end_seconds)
	);

	gpio_edge_event_debouncer_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.first_pin(first_pin),
		.end_pin(end_pin),
		.pending_bits(pending_bits),
		.edge_bits(edge_bits),
		.now_ticks(now_ticks),
		.now_seconds(now_seconds),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.pin(pin),
		.notify(notify),
		.edge_kind(edge_kind),
		.event_ticks(event_ticks),
		.falling_ticks(falling_ticks),
		.start_seconds(start_seconds),
		.end_seconds(end_seconds),
		.fail_count(fail_count),
		.outstanding(outstanding),
		.words_in(words_in),
		.notified(notified),
		.filtered(filtered),
		.empty_scans(empty_scans)
	);

	// result side: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			out_ready <= 1'b0;
			repeat (LONG_HOLD) @(posedge clk);
			hold_done = 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_word(input logic [6:0] first, input logic [6:0] last,
			input logic [31:0] pend, input logic [31:0] edges, input logic [31:0] now,
			input logic [31:0] secs);
		first_pin <= first;
		end_pin <= last;
		pending_bits <= pend;
		edge_bits <= edges;
		now_ticks <= now;
		now_seconds <= secs;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_window(input logic [15:0] ticks);
		cfg_data <= ticks;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		window_now = ticks;
	endtask

	task automatic random_word();
		logic [6:0] first;
		logic [6:0] last;
		logic [31:0] pend;
		int k;
		if ($urandom_range(99) < 80) begin
			// a few hot pins per bank so the same records keep getting hit
			first = 7'($urandom_range(2) * 32);
			last = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : first + 7'd32;
			k = $urandom_range(1) ? $urandom_range(3) : 28 + $urandom_range(3);
			pend = 32'd1 << k;
			if ($urandom_range(3) == 0)
				pend = pend | ($urandom & ~((32'd2 << k) - 32'd1));
			tick_base = tick_base + $urandom_range(window_now * 2 + 2);
			if ($urandom_range(49) == 0)
				tick_base = tick_base + $urandom;
			sec_base = sec_base + $urandom_range(1);
			send_word(first, last, pend, $urandom, tick_base, sec_base);
		end else begin
			send_word(7'($urandom), 7'($urandom), $urandom, $urandom, $urandom, $urandom);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// range handling
		send_word(7'd10, 7'd10, '1, '1, 32'd5, 32'd1);
		send_word(7'd50, 7'd20, '1, '0, 32'd6, 32'd1);
		send_word(7'd0, 7'd32, '0, '1, 32'd7, 32'd1);
		send_word(7'd0, 7'd4, 32'hFFFF_FFF0, '1, 32'd8, 32'd1);
		send_word(7'd90, 7'd127, 32'h0000_0040, '1, 32'd9, 32'd1);
		send_word(7'd90, 7'd127, 32'h0000_0060, '1, 32'd9, 32'd2);
		send_word(7'd0, 7'd100, 32'h8000_0000, '1, 32'd10, 32'd2);
		send_word(7'd127, 7'd127, '1, '1, '1, '1);
		// rising at tick zero leaves a zero rise time, so later rising edges never filter
		send_word(7'd95, 7'd96, 32'd1, 32'd1, 32'd0, 32'd3);
		send_word(7'd95, 7'd96, 32'd1, 32'd1, 32'd1, 32'd3);
		// window edges
		send_word(7'd0, 7'd32, 32'd8, 32'd8, 32'd1000, 32'd5);
		send_word(7'd0, 7'd32, 32'd8, 32'd8, 32'd1020, 32'd5);
		send_word(7'd0, 7'd32, 32'd8, 32'd0, 32'd1040, 32'd6);
		send_word(7'd0, 7'd32, 32'd8, 32'd0, 32'd1041, 32'd6);
		send_word(7'd0, 7'd32, 32'd8, 32'd8, 32'd1040, 32'd7);
		send_word(7'd0, 7'd32, 32'd8, 32'd8, 32'd1041, 32'd7);
		// tick wrap
		send_word(7'd0, 7'd32, 32'h80, 32'h80, 32'hFFFF_FFF0, 32'd10);
		send_word(7'd0, 7'd32, 32'h80, 32'h80, 32'h0000_0010, 32'd10);
		send_word(7'd0, 7'd32, 32'h80, 32'h00, 32'h0000_0018, 32'd11);
		send_word(7'd0, 7'd32, 32'h80, 32'h00, 32'h0000_0019, 32'd11);
		// falling on a pin that never rose
		send_word(7'd32, 7'd64, 32'h100, 32'h0, 32'd20, 32'd12);
		send_word(7'd32, 7'd64, 32'h100, 32'h0, 32'h8000_0028, 32'd12);
		// field extremes and lowest pending pick
		send_word(7'd64, 7'd96, '1, 32'hAAAA_AAAA, '1, '1);
		send_word(7'd32, 7'd64, 32'h8000_0100, '1, 32'h1234_5678, 32'h55);
		send_word(7'd0, 7'd1, '1, '1, '1, 32'd0);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			set_window((phase_window[ph] < 0) ? 16'($urandom) : 16'(phase_window[ph]));
			send_idle_pct = phase_send_idle[ph];
			recv_stall_pct = phase_recv_stall[ph];
			if (ph == 4)
				hold_req = 1'b1;
			repeat (WORDS_PER_PHASE) random_word();
			drain();
		end

		$display("covered %0d bank snapshots: %0d events reported, %0d filtered, %0d empty",
			words_in, notified, filtered, empty_scans);
		$display("debounce windows 0, 1, 40, 65535 and random, with gaps, stalls and a %0d cycle hold",
			LONG_HOLD);
		if (fail_count == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#1000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/ged_pkg.sv
rtl/ged_ram.sv
rtl/ged_front.sv
rtl/ged_queue.sv
rtl/ged_back.sv
rtl/gpio_edge_event_debouncer.sv
test/gpio_edge_event_debouncer_checker.sv
test/gpio_edge_event_debouncer_tb.sv
